// File: sv/assert_macros.svh
// assertion macros shared by the frame parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while in reset
`define DSFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked implication, off while in reset
`define DSFP_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

// File: sv/dsfp_pkg.sv
// types, constants and helpers of the dust sensor frame parser
`timescale 1ns / 1ps
package dsfp_pkg;

  localparam int FRAME_BYTES = 10;
  localparam logic [3:0] LAST_INDEX = 4'(FRAME_BYTES - 1);

  localparam logic [7:0] HEAD_BYTE = 8'hAA;
  localparam logic [7:0] CMD_BYTE  = 8'hC0;
  localparam logic [7:0] TAIL_BYTE = 8'hAB;

  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;

  typedef enum logic [0:0] {
    KIND_BYTE    = 1'b0,
    KIND_TIMEOUT = 1'b1
  } kind_t;

  typedef enum logic [0:0] {
    CFG_REPORT_MODE   = 1'b0,
    CFG_PARTICLE_SIZE = 1'b1
  } cfg_index_t;

  typedef enum logic [0:0] {
    MODE_BOTH   = 1'b0,
    MODE_SINGLE = 1'b1
  } report_mode_t;

  typedef enum logic [1:0] {
    SIZE_PM25 = 2'd0,
    SIZE_PM10 = 2'd1,
    SIZE_UNSUP = 2'd2,
    SIZE_RSVD = 2'd3
  } particle_size_t;

  typedef enum logic [2:0] {
    ST_BOTH_OK   = 3'd0,
    ST_SINGLE_OK = 3'd1,
    ST_FRAMING   = 3'd2,
    ST_CHECKSUM  = 3'd3,
    ST_UNSUP     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    VERD_FRAMING  = 2'd0,
    VERD_CHECKSUM = 2'd1,
    VERD_GOOD     = 2'd2
  } verdict_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [15:0] pm25_raw;
    logic [15:0] pm10_raw;
  } rec_t;

  // exact for every 16-bit value
  function automatic logic [12:0] div10(input logic [15:0] x);
    logic [31:0] prod;
    prod = x * DIV10_MUL;
    return prod[DIV10_SHIFT +: 13];
  endfunction

endpackage

// File: sv/dsfp_if.sv
// valid/ready channel interfaces of the frame parser
`timescale 1ns / 1ps
interface dsfp_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] kind;
  logic [7:0] rx_byte;

  modport source (output valid, kind, rx_byte, input ready);
  modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface dsfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [12:0] pm25_value;
  logic [12:0] pm10_value;
  logic [12:0] single_value;

  modport source (output valid, status, pm25_value, pm10_value, single_value, input ready);
  modport sink   (input valid, status, pm25_value, pm10_value, single_value, output ready);
endinterface

// File: sv/dsfp_front.sv
// frame assembly and verdict of each received frame
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dsfp_front (
  input  logic           clk,
  input  logic           rst_n,
  dsfp_in_if.sink        in_ch,
  input  logic           q_full,
  output logic           push,
  output dsfp_pkg::rec_t push_rec
);
  import dsfp_pkg::*;

  logic [3:0]  byte_index_r, byte_index_nxt;
  logic        markers_ok_r, markers_ok_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [15:0] pm25_raw_r, pm25_raw_nxt;
  logic [15:0] pm10_raw_r, pm10_raw_nxt;
  logic [7:0]  received_sum_r, received_sum_nxt;

  logic accept;
  logic is_timeout;
  logic is_last;
  logic tail_ok;
  logic [7:0] b;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign is_timeout  = (kind_t'(in_ch.kind) == KIND_TIMEOUT);
  assign is_last     = (byte_index_r >= LAST_INDEX);
  assign tail_ok     = markers_ok_r && (b == TAIL_BYTE);
  assign push        = accept && (is_timeout || is_last);

  always_comb begin
    push_rec.pm25_raw = pm25_raw_r;
    push_rec.pm10_raw = pm10_raw_r;
    priority if (is_timeout || !tail_ok) begin
      push_rec.verdict = VERD_FRAMING;
    end else if (running_sum_r != received_sum_r) begin
      push_rec.verdict = VERD_CHECKSUM;
    end else begin
      push_rec.verdict = VERD_GOOD;
    end
  end

  always_comb begin
    byte_index_nxt   = byte_index_r;
    markers_ok_nxt   = markers_ok_r;
    running_sum_nxt  = running_sum_r;
    pm25_raw_nxt     = pm25_raw_r;
    pm10_raw_nxt     = pm10_raw_r;
    received_sum_nxt = received_sum_r;
    if (accept) begin
      if (is_timeout || is_last) begin
        byte_index_nxt   = '0;
        markers_ok_nxt   = 1'b1;
        running_sum_nxt  = '0;
        pm25_raw_nxt     = '0;
        pm10_raw_nxt     = '0;
        received_sum_nxt = '0;
      end else begin
        unique case (byte_index_r)
          4'd0: if (b != HEAD_BYTE) markers_ok_nxt = 1'b0;
          4'd1: if (b != CMD_BYTE) markers_ok_nxt = 1'b0;
          4'd2: pm25_raw_nxt[7:0]  = b;
          4'd3: pm25_raw_nxt[15:8] = b;
          4'd4: pm10_raw_nxt[7:0]  = b;
          4'd5: pm10_raw_nxt[15:8] = b;
          4'd8: received_sum_nxt   = b;
          default: ;
        endcase
        if (byte_index_r >= 4'd2 && byte_index_r <= 4'd7) begin
          running_sum_nxt = running_sum_r + b;
        end
        byte_index_nxt = byte_index_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r   <= '0;
      markers_ok_r   <= 1'b1;
      running_sum_r  <= '0;
      pm25_raw_r     <= '0;
      pm10_raw_r     <= '0;
      received_sum_r <= '0;
    end else begin
      byte_index_r   <= byte_index_nxt;
      markers_ok_r   <= markers_ok_nxt;
      running_sum_r  <= running_sum_nxt;
      pm25_raw_r     <= pm25_raw_nxt;
      pm10_raw_r     <= pm10_raw_nxt;
      received_sum_r <= received_sum_nxt;
    end
  end

  `DSFP_ASSERT_IMP(a_push_restarts_frame, push, ##1 (byte_index_r == 4'd0 && markers_ok_r), "frame state not cleared after verdict")
  `DSFP_ASSERT(a_index_in_frame, byte_index_r <= LAST_INDEX, "byte index beyond frame")

endmodule

// File: sv/dsfp_queue.sv
// two-entry queue between frame front and result back
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dsfp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dsfp_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output logic           rd_valid,
  output dsfp_pkg::rec_t rd_rec
);
  import dsfp_pkg::*;

  rec_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = !wr_ptr_r;
    if (pop) rd_ptr_nxt = !rd_ptr_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `DSFP_ASSERT(a_no_push_full, !(push && full), "push into full queue")
  `DSFP_ASSERT(a_no_pop_empty, !(pop && !rd_valid), "pop from empty queue")
  `DSFP_ASSERT(a_ptr_count, (count_r == 2'd1) == (wr_ptr_r != rd_ptr_r), "queue pointers and count disagree")

endmodule

// File: sv/dsfp_back.sv
// config registers, divide by ten, value selection and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dsfp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_index,
  input  logic [1:0]     cfg_wdata,
  input  logic           rd_valid,
  input  dsfp_pkg::rec_t rd_rec,
  output logic           pop,
  dsfp_out_if.source     out_ch
);
  import dsfp_pkg::*;

  report_mode_t   report_mode_r;
  particle_size_t particle_size_r;

  logic        out_valid_r;
  status_t     status_r;
  logic [12:0] pm25_r, pm10_r, single_r;

  status_t     status_nxt;
  logic [12:0] pm25_nxt, pm10_nxt, single_nxt;
  logic [12:0] v25, v10;

  assign pop = rd_valid && (!out_valid_r || out_ch.ready);
  assign v25 = div10(rd_rec.pm25_raw);
  assign v10 = div10(rd_rec.pm10_raw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_mode_r   <= MODE_BOTH;
      particle_size_r <= SIZE_PM25;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_REPORT_MODE:   report_mode_r   <= report_mode_t'(cfg_wdata[0]);
        CFG_PARTICLE_SIZE: particle_size_r <= particle_size_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    status_nxt = ST_FRAMING;
    pm25_nxt   = '0;
    pm10_nxt   = '0;
    single_nxt = '0;
    unique case (rd_rec.verdict)
      VERD_CHECKSUM: status_nxt = ST_CHECKSUM;
      VERD_GOOD: begin
        if (report_mode_r == MODE_BOTH) begin
          status_nxt = ST_BOTH_OK;
          pm25_nxt   = v25;
          pm10_nxt   = v10;
        end else begin
          unique case (particle_size_r)
            SIZE_PM25: begin
              status_nxt = ST_SINGLE_OK;
              pm25_nxt   = v25;
              pm10_nxt   = v10;
              single_nxt = v25;
            end
            SIZE_PM10: begin
              status_nxt = ST_SINGLE_OK;
              pm25_nxt   = v25;
              pm10_nxt   = v10;
              single_nxt = v10;
            end
            default: status_nxt = ST_UNSUP;
          endcase
        end
      end
      default: status_nxt = ST_FRAMING;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= status_nxt;
      pm25_r   <= pm25_nxt;
      pm10_r   <= pm10_nxt;
      single_r <= single_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.pm25_value   = pm25_r;
  assign out_ch.pm10_value   = pm10_r;
  assign out_ch.single_value = single_r;

  `DSFP_ASSERT_IMP(a_pop_loads_output, pop, ##1 out_valid_r, "popped record not presented")

endmodule

// File: sv/dust_sensor_frame_parser_top.sv
// dust sensor frame parser: one byte or timeout beat per cycle while in_ch.ready is high,
// one result per frame, valid once its verdict has passed the queue and output register
// throughput: one input beat per cycle while the queue is not full; a stalled output
// holds up to two verdicts in the queue before in_ch.ready drops
// reset (synchronous, rst_n low): frame state cleared, config at defaults, queue empty
`timescale 1ns / 1ps
module dust_sensor_frame_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [1:0] cfg_wdata,
  dsfp_in_if.sink    in_ch,
  dsfp_out_if.source out_ch
);
  import dsfp_pkg::*;

  logic q_full;
  logic push;
  logic pop;
  logic rd_valid;
  rec_t push_rec;
  rec_t rd_rec;

  dsfp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  dsfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (rd_valid),
    .rd_rec   (rd_rec)
  );

  dsfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rd_valid  (rd_valid),
    .rd_rec    (rd_rec),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
